// File: design/pidaw_pkg.sv
// pidaw_pkg: widths, register indexes, datapath op codes and shared types
// for the pid controller with back-calculation anti-windup
// no dependencies
package pidaw_pkg;

  localparam int ERR_W  = 32;
  localparam int DT_W   = 24;
  localparam int GAIN_W = 32;
  localparam int LIM_W  = 31;
  localparam int ST_W   = 48;
  localparam int FRAC_W = 16;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int DERIV_COEF_DEF = 100;
  localparam int BACKCALC_GAIN  = 100;

  localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
  localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_OUT_LIMIT  = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MP,
    OP_MD,
    OP_MI,
    OP_DC,
    OP_SUM,
    OP_CLAMP,
    OP_TERM,
    OP_MTH,
    OP_MTL,
    OP_MDH,
    OP_MDL,
    OP_UPD
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
    logic   push;
  } pidaw_cmd_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic        [LIM_W-1:0]  out_limit;
  } pidaw_cfg_t;

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [63:0] x);
    logic signed [ST_W-1:0] r;
    if (x > 64'(ST_MAX)) begin
      r = ST_MAX;
    end else if (x < 64'(ST_MIN)) begin
      r = ST_MIN;
    end else begin
      r = x[ST_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/pidaw_in_if.sv
// pidaw_in_if: input channel, one beat per controller step
// depends on pidaw_pkg
interface pidaw_in_if;
  import pidaw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ERR_W-1:0] err_in;
  logic        [DT_W-1:0]  delta_t;
  logic                    clear_req;

  modport source (output valid, err_in, delta_t, clear_req, input ready);
  modport sink (input valid, err_in, delta_t, clear_req, output ready);
endinterface

// File: design/pidaw_out_if.sv
// pidaw_out_if: result channel, one beat per controller step
// depends on pidaw_pkg
interface pidaw_out_if;
  import pidaw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ERR_W-1:0] drive_out;

  modport source (output valid, drive_out, input ready);
  modport sink (input valid, drive_out, output ready);
endinterface

// File: design/pidaw_regs.sv
// pidaw_regs: apb register file for gains and output limit
// depends on pidaw_pkg
module pidaw_regs import pidaw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output pidaw_cfg_t        cfg_o
);

  pidaw_cfg_t cfg_q;
  reg_idx_e   idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:  cfg_q.prop_gain  <= signed'(pwdata[GAIN_W-1:0]);
        REG_INTEG_GAIN: cfg_q.integ_gain <= signed'(pwdata[GAIN_W-1:0]);
        REG_DERIV_GAIN: cfg_q.deriv_gain <= signed'(pwdata[GAIN_W-1:0]);
        REG_OUT_LIMIT:  cfg_q.out_limit  <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:  prdata = DATA_W'(unsigned'(cfg_q.prop_gain));
      REG_INTEG_GAIN: prdata = DATA_W'(unsigned'(cfg_q.integ_gain));
      REG_DERIV_GAIN: prdata = DATA_W'(unsigned'(cfg_q.deriv_gain));
      REG_OUT_LIMIT:  prdata = DATA_W'(cfg_q.out_limit);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: design/pidaw_ctrl.sv
// pidaw_ctrl: sequencer for one controller step over the shared multiplier
// depends on pidaw_pkg
module pidaw_ctrl import pidaw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output pidaw_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MP,
    ST_MD,
    ST_MI,
    ST_DC,
    ST_SUM,
    ST_CLAMP,
    ST_TERM,
    ST_MTH,
    ST_MTL,
    ST_MDH,
    ST_MDL,
    ST_UPD,
    ST_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  dp_op_e op;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MP;
      end
      ST_MP:    begin op = OP_MP;    state_d = ST_MD;    end
      ST_MD:    begin op = OP_MD;    state_d = ST_MI;    end
      ST_MI:    begin op = OP_MI;    state_d = ST_DC;    end
      ST_DC:    begin op = OP_DC;    state_d = ST_SUM;   end
      ST_SUM:   begin op = OP_SUM;   state_d = ST_CLAMP; end
      ST_CLAMP: begin op = OP_CLAMP; state_d = ST_TERM;  end
      ST_TERM:  begin op = OP_TERM;  state_d = ST_MTH;   end
      ST_MTH:   begin op = OP_MTH;   state_d = ST_MTL;   end
      ST_MTL:   begin op = OP_MTL;   state_d = ST_MDH;   end
      ST_MDH:   begin op = OP_MDH;   state_d = ST_MDL;   end
      ST_MDL:   begin op = OP_MDL;   state_d = ST_UPD;   end
      ST_UPD:   begin op = OP_UPD;   state_d = ST_PUSH;  end
      ST_PUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load = in_valid_i && in_ready_o;
    cmd_o.op   = op;
    cmd_o.push = (state_q == ST_PUSH) && out_free;
  end

  always_comb begin
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/pidaw_dp.sv
// pidaw_dp: controller state, shared 33x33 multiplier and step arithmetic
// depends on pidaw_pkg; driven by pidaw_ctrl commands
module pidaw_dp import pidaw_pkg::*; #(
  parameter int DerivFilterCoef = DERIV_COEF_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pidaw_cmd_t              cmd_i,
  input  pidaw_cfg_t              cfg_i,
  input  logic signed [ERR_W-1:0] err_in_i,
  input  logic        [DT_W-1:0]  delta_t_i,
  input  logic                    clear_req_i,
  output logic signed [ERR_W-1:0] drive_out_o
);

  localparam int CoefW = $clog2(DerivFilterCoef + 1) + 1;
  localparam int DiffW = ST_W + 1;
  localparam int DprW  = DiffW + CoefW;
  localparam int SumW  = ST_W + 2;
  localparam int ExcW  = SumW + 1;
  localparam int BcW   = ExcW + $clog2(BACKCALC_GAIN + 1) + 2;

  logic signed [ERR_W-1:0]  err_q;
  logic        [DT_W-1:0]   dt_q;
  logic                     prev_clear_q;
  logic signed [ST_W-1:0]   integ_q;
  logic signed [ST_W-1:0]   filt_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ST_W-1:0]   p_q;
  logic signed [DiffW-1:0]  diff_q;
  logic signed [ST_W-1:0]   ierr_q;
  logic signed [ST_W-1:0]   d_q;
  logic signed [SumW-1:0]   sum_q;
  logic signed [ERR_W-1:0]  lim_q;
  logic signed [ExcW-1:0]   exc_q;
  logic signed [ST_W-1:0]   term_q;
  logic signed [ST_W-1:0]   acc_q;
  logic signed [ERR_W-1:0]  drive_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [ST_W-1:0]   prod_shr;
  logic signed [SumW-1:0]   prod_frac;
  logic signed [SumW-1:0]   lim_pos, lim_w;
  logic signed [DprW-1:0]   dprod;
  logic signed [BcW-1:0]    bc_sum;
  logic signed [SumW-1:0]   integ_sum, filt_sum;

  assign drive_out_o = drive_q;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MP: begin
        mul_a = MUL_W'(err_q);
        mul_b = MUL_W'(cfg_i.prop_gain);
      end
      OP_MD: begin
        mul_a = MUL_W'(err_q);
        mul_b = MUL_W'(cfg_i.deriv_gain);
      end
      OP_MI: begin
        mul_a = MUL_W'(err_q);
        mul_b = MUL_W'(cfg_i.integ_gain);
      end
      OP_MTH: begin
        mul_a = MUL_W'(signed'(term_q[ST_W-1:DT_W]));
        mul_b = signed'(MUL_W'(dt_q));
      end
      OP_MTL: begin
        mul_a = signed'(MUL_W'(term_q[DT_W-1:0]));
        mul_b = signed'(MUL_W'(dt_q));
      end
      OP_MDH: begin
        mul_a = MUL_W'(signed'(d_q[ST_W-1:DT_W]));
        mul_b = signed'(MUL_W'(dt_q));
      end
      OP_MDL: begin
        mul_a = signed'(MUL_W'(d_q[DT_W-1:0]));
        mul_b = signed'(MUL_W'(dt_q));
      end
      default: ;
    endcase
  end

  // gain products rescaled by floor shift, low dt products by floor shift
  assign prod_shr  = signed'(prod_q[FRAC_W+ST_W-1:FRAC_W]);
  assign prod_frac = SumW'(signed'({1'b0, prod_q[ST_W-1:DT_W]}));

  assign dprod     = DprW'(diff_q) * DprW'(DerivFilterCoef);
  assign bc_sum    = BcW'(ierr_q) + BcW'(exc_q) * BcW'(BACKCALC_GAIN);
  assign integ_sum = SumW'(integ_q) + SumW'(acc_q) + prod_frac;
  assign filt_sum  = SumW'(filt_q) + SumW'(acc_q) + prod_frac;

  always_comb begin
    lim_pos = SumW'(signed'({1'b0, cfg_i.out_limit}));
    if (sum_q > lim_pos) begin
      lim_w = lim_pos;
    end else if (sum_q < -lim_pos) begin
      lim_w = -lim_pos;
    end else begin
      lim_w = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clear_q <= 1'b0;
      integ_q      <= '0;
      filt_q       <= '0;
    end else if (cmd_i.load) begin
      prev_clear_q <= clear_req_i;
      if (clear_req_i || prev_clear_q) begin
        integ_q <= '0;
        filt_q  <= '0;
      end
    end else if (cmd_i.op == OP_MDH) begin
      integ_q <= sat_st(64'(integ_sum));
    end else if (cmd_i.op == OP_UPD) begin
      filt_q <= sat_st(64'(filt_sum));
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load) begin
      err_q <= err_in_i;
      dt_q  <= delta_t_i;
    end
    if (cmd_i.push) begin
      drive_q <= lim_q;
    end
    case (cmd_i.op)
      OP_MD:    p_q    <= prod_shr;
      OP_MI:    diff_q <= DiffW'(prod_shr) - DiffW'(filt_q);
      OP_DC: begin
        ierr_q <= prod_shr;
        d_q    <= sat_st(64'(dprod));
      end
      OP_SUM:   sum_q  <= SumW'(p_q) + SumW'(integ_q) + SumW'(d_q);
      OP_CLAMP: begin
        lim_q <= lim_w[ERR_W-1:0];
        exc_q <= ExcW'(lim_w) - ExcW'(sum_q);
      end
      OP_TERM:  term_q <= sat_st(64'(bc_sum));
      OP_MTL:   acc_q  <= prod_q[ST_W-1:0];
      OP_MDL:   acc_q  <= prod_q[ST_W-1:0];
      default: ;
    endcase
  end

endmodule

// File: design/pid_antiwindup_filtered_derivative.sv
// pid_antiwindup_filtered_derivative: pid controller step with filtered
// derivative, output clamp and back-calculation anti-windup
// depends on pidaw_pkg, pidaw_in_if, pidaw_out_if, pidaw_regs, pidaw_ctrl, pidaw_dp
//
// usage
//   in_i carries one beat per controller update: err_in (q16.16), delta_t
//   (q0.24) and clear_req. out_o returns one beat per input beat with the
//   clamped drive_out (q16.16), in order.
//   gains and out_limit are set through the apb port at 4*index; write them
//   only while no beat is in flight.
// sequence
//   a beat runs through a 12-step sequence over the single 33x33 multiplier
//   (three gain products and four partial products against delta_t) and then
//   the push into the output register; a new beat is accepted only once the
//   previous one has been pushed.
// reset
//   integrator, derivative filter, clear history and all gains go to zero.
// stalls
//   the result sits in the output register; a new beat may be accepted while
//   it waits, and the next result is held back until the output is taken.
module pid_antiwindup_filtered_derivative import pidaw_pkg::*; #(
  parameter int DerivFilterCoef = DERIV_COEF_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pidaw_in_if.sink          in_i,
  pidaw_out_if.source       out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  pidaw_cfg_t cfg;
  pidaw_cmd_t cmd;

  pidaw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidaw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  pidaw_dp #(
    .DerivFilterCoef (DerivFilterCoef)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .err_in_i    (in_i.err_in),
    .delta_t_i   (in_i.delta_t),
    .clear_req_i (in_i.clear_req),
    .drive_out_o (out_o.drive_out)
  );

`ifndef SYNTH
  a_one_beat_in_flight : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready
  ) else $error("input accepted on consecutive cycles");

  a_push_shows_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> out_o.valid
  ) else $error("result push did not raise out valid");

  a_valid_from_push : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.push)
  ) else $error("out valid rose without a result push");

  a_no_push_on_load : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !cmd.push
  ) else $error("load and push in the same cycle");
`endif

endmodule

// File: sim/pid_antiwindup_filtered_derivative_test.sv
// pid_antiwindup_filtered_derivative_test: self-checking bench for the pid step with
// anti-windup, driving beats, apb gain writes and a bit-exact predictor of drive_out
// depends on pidaw_pkg, pidaw_in_if, pidaw_out_if and the pid_antiwindup_filtered_derivative rtl
module pid_antiwindup_filtered_derivative_test;
  import pidaw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     STALL_LIMIT = 2000;
  localparam int     SETTLE_CYC  = 16;
  localparam longint HI48        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint LO48        = -HI48 - 1;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic        [DT_W-1:0]  dt;
    logic                    clr;
  } pid_step_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pidaw_in_if  in_ch ();
  pidaw_out_if out_ch ();

  pid_antiwindup_filtered_derivative DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pid_step_t               step_q[$];
  logic signed [ERR_W-1:0] drive_q[$];
  pid_step_t               cur_step;
  logic signed [ERR_W-1:0] want;
  logic                    in_fire = 1'b0;
  logic                    idle_en = 1'b1;
  int                      in_gap = 0;
  int                      out_gap = 0;
  int                      fail_cnt = 0;
  int                      stall_cnt = 0;

  longint gain_p = 0;
  longint gain_i = 0;
  longint gain_d = 0;
  longint clamp_mag = 0;
  longint integ_acc = 0;
  longint filt_acc = 0;
  logic   clear_hist = 1'b0;

  function automatic longint clip48(longint x);
    if (x > HI48) begin
      return HI48;
    end else if (x < LO48) begin
      return LO48;
    end
    return x;
  endfunction

  // floor of t * dt / 2^24, wide enough for a full 48-bit state value
  function automatic longint dt_scale(longint t, logic [DT_W-1:0] dt);
    logic signed [79:0] tw;
    logic signed [79:0] dw;
    tw = 80'(t);
    dw = {56'd0, dt};
    tw = tw * dw;
    return longint'(tw >>> DT_W);
  endfunction

  function automatic logic signed [ERR_W-1:0] next_drive(pid_step_t s);
    longint e, p, d, sum, lim, ierr, term;
    e = longint'($signed(s.err));
    if (s.clr || clear_hist) begin
      integ_acc = 0;
      filt_acc = 0;
    end
    p = (e * gain_p) >>> FRAC_W;
    d = clip48((((e * gain_d) >>> FRAC_W) - filt_acc) * DERIV_COEF_DEF);
    sum = p + integ_acc + d;
    if (sum > clamp_mag) begin
      lim = clamp_mag;
    end else if (sum < -clamp_mag) begin
      lim = -clamp_mag;
    end else begin
      lim = sum;
    end
    ierr = (e * gain_i) >>> FRAC_W;
    term = clip48(ierr + BACKCALC_GAIN * (lim - sum));
    integ_acc = clip48(integ_acc + dt_scale(term, s.dt));
    filt_acc = clip48(filt_acc + dt_scale(d, s.dt));
    clear_hist = s.clr;
    return lim[ERR_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(30, 60);
  endfunction

  task automatic note_fail(string what, logic [ERR_W-1:0] exp_v, logic [ERR_W-1:0] got_v);
    if (fail_cnt < 10) begin
      $display("%0t %s: expected %h got %h", $realtime, what, exp_v, got_v);
    end
    fail_cnt++;
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        in_gap = pick_gap();
      end
      if (!in_ch.valid || in_fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
          in_ch.err_in <= $urandom;
          in_ch.delta_t <= DT_W'($urandom);
          in_ch.clear_req <= 1'($urandom_range(0, 1));
        end else if (step_q.size() != 0) begin
          cur_step = step_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.err_in <= cur_step.err;
          in_ch.delta_t <= cur_step.dt;
          in_ch.clear_req <= cur_step.clr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result sink stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          out_gap = pick_gap();
        end
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          note_fail("unexpected drive_out beat", '0, out_ch.drive_out);
        end else begin
          want = drive_q.pop_front();
          if (want !== out_ch.drive_out) begin
            note_fail("drive_out mismatch", want, out_ch.drive_out);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        drive_q.push_back(next_drive(cur_step));
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable && pready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt + 1 >= STALL_LIMIT) begin
        $display("pid_antiwindup_filtered_derivative regression: fail");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  task automatic cfg_write(reg_idx_e idx, logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PROP_GAIN:  gain_p = longint'($signed(val));
      REG_INTEG_GAIN: gain_i = longint'($signed(val));
      REG_DERIV_GAIN: gain_d = longint'($signed(val));
      REG_OUT_LIMIT:  clamp_mag = longint'(val[LIM_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pwdata <= $urandom;
  endtask

  task automatic set_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd, logic [31:0] lim);
    cfg_write(REG_PROP_GAIN, kp);
    cfg_write(REG_INTEG_GAIN, ki);
    cfg_write(REG_DERIV_GAIN, kd);
    cfg_write(REG_OUT_LIMIT, lim);
  endtask

  task automatic add_step(logic [31:0] err, logic [23:0] dt, logic clr);
    step_q.push_back('{err: err, dt: dt, clr: clr});
  endtask

  task automatic drain();
    while (step_q.size() != 0 || drive_q.size() != 0 || in_ch.valid) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($urandom_range(0, 524288)) - 32'd262144;
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 5))
      0: return {1'($urandom_range(0, 1)), 31'd0};
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 16777216))};
    endcase
  endfunction

  function automatic logic [31:0] rand_err();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
    endcase
  endfunction

  function automatic logic [23:0] rand_dt();
    case ($urandom_range(0, 7))
      0, 1: return DT_W'($urandom);
      2: return $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd0;
      default: return DT_W'($urandom_range(1, 65536));
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.err_in = '0;
    in_ch.delta_t = '0;
    in_ch.clear_req = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // gains and limit still at reset, output pinned to zero
    add_step(32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0);
    add_step(32'h8000_0000, 24'hFF_FFFF, 1'b0);
    drain();

    // moderate gains, limit 100.0
    set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_028F, 32'h0064_0000);
    add_step(32'h0001_0000, 24'd16777, 1'b0);
    add_step(32'hFFFF_0000, 24'd16777, 1'b0);
    add_step(32'h0000_0000, 24'd16777, 1'b0);
    add_step(32'hFFFF_FFFF, 24'd16777, 1'b0);
    add_step(32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0);
    add_step(32'h8000_0000, 24'hFF_FFFF, 1'b0);
    add_step(32'h0005_0000, 24'd0, 1'b0);
    add_step(32'h0005_0000, 24'd16777, 1'b1);
    add_step(32'h0005_0000, 24'd16777, 1'b0);
    add_step(32'h0005_0000, 24'd16777, 1'b1);
    add_step(32'h0005_0000, 24'd16777, 1'b1);
    add_step(32'hFFFD_0000, 24'd1, 1'b0);
    drain();

    // extreme gains, derivative and state saturation
    set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_step(32'h8000_0000, 24'hFF_FFFF, 1'b0);
    add_step(32'h8000_0000, 24'hFF_FFFF, 1'b0);
    add_step(32'h8000_0000, 24'hFF_FFFF, 1'b0);
    add_step(32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0);
    add_step(32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0);
    add_step(32'h0000_0000, 24'hFF_FFFF, 1'b0);
    drain();

    // zero limit, top bit of the limit word ignored
    set_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_step(32'h8000_0000, 24'hFF_FFFF, 1'b0);
    add_step(32'h7FFF_FFFF, 24'h80_0000, 1'b0);
    add_step(32'h1234_5678, 24'h00_1000, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      idle_en = (ph % 3) != 1;
      set_gains(rand_gain(), rand_gain(), rand_gain(), rand_limit());
      for (int n = 0; n < 150; n++) begin
        add_step(rand_err(), rand_dt(), $urandom_range(0, 19) == 0);
      end
      drain();
    end

    if (drive_q.size() != 0) begin
      note_fail("drive_out beats missing", drive_q[0], '0);
    end
    if (fail_cnt == 0) begin
      $display("pid_antiwindup_filtered_derivative regression: pass");
    end else begin
      $display("pid_antiwindup_filtered_derivative regression: fail");
    end
    $finish;
  end

endmodule
